/* hw/rtl/dwrs_pkg.sv */
// shared types and constants for the draw-without-replacement shuffler
// no dependencies; imported by dwrs_cfg, the top level and the checker

package dwrs_pkg;

    localparam int MAX_VALUES_DEF = 1024;

    // configuration port geometry: three 32-bit registers at 4*i
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NO_REPEAT = 2'd2;

    typedef enum logic [1:0] {
        ACT_DRAW      = 2'd0,
        ACT_RESHUFFLE = 2'd1,
        ACT_RESTART   = 2'd2,
        ACT_REBUILD   = 2'd3
    } action_t;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic               no_repeat;
    } cfg_t;

endpackage

/* hw/rtl/dwrs_if.sv */
// valid/ready channel interfaces for the shuffler: action beats in, drawn values out
// standalone; no package dependency

interface dwrs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] random_word;

    modport source (output valid, output action, output random_word, input ready);
    modport sink   (input valid, input action, input random_word, output ready);
endinterface

interface dwrs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drawn_value;

    modport source (output valid, output drawn_value, input ready);
    modport sink   (input valid, input drawn_value, output ready);
endinterface

/* hw/rtl/dwrs_cfg.sv */
// apb-style configuration registers: min_value, max_value, no_repeat
// depends on dwrs_pkg for register indexes and the cfg_t struct

module dwrs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dwrs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dwrs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [dwrs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output dwrs_pkg::cfg_t                     cfg
);
    import dwrs_pkg::*;

    logic signed [31:0]   min_value_reg;
    logic signed [31:0]   max_value_reg;
    logic                 no_repeat_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= 32'sd0;
            max_value_reg <= 32'sd1;
            no_repeat_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_VALUE: min_value_reg <= pwdata;
                REG_MAX_VALUE: max_value_reg <= pwdata;
                REG_NO_REPEAT: no_repeat_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_VALUE: prdata = min_value_reg;
            REG_MAX_VALUE: prdata = max_value_reg;
            REG_NO_REPEAT: prdata = {{(CFG_DATA_W-1){1'b0}}, no_repeat_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.min_value = min_value_reg;
    assign cfg.max_value = max_value_reg;
    assign cfg.no_repeat = no_repeat_reg;

endmodule

/* hw/rtl/dwrs_perm_ram.sv */
// permutation store: one write port, two registered read ports
// no package dependency; sized by the top level

module dwrs_perm_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = AW
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* hw/rtl/draw_without_replacement_shuffler.sv */
// top level of the draw-without-replacement shuffler: sequencer around the permutation store
// depends on dwrs_pkg, dwrs_if, dwrs_cfg and dwrs_perm_ram

// Deals the integers min_value..max_value in random order, each once per pass through the
// range, from a permutation store of MAX_VALUES entries held in a one-write, two-read RAM
// with registered read ports. Items are taken one at a time. A draw runs decode, advance, a
// multiply of the random word for the offset, a read of both entries, then two writes for
// the swap through the single write port, and holds in the second write while the output
// register is full; reshuffle and restart skip advance and multiply; a rebuild ends at
// decode. When a rebuild is due (rebuild action, changed bounds, or the first draw after
// reset) and the store has been altered since it was last filled, a walk first rewrites the
// identity in all MAX_VALUES entries. After reset the block runs that walk once before its
// first item; configuration writes are accepted at any time. A finished draw waits in an
// output register, so the next item is taken while the result is still pending.

module draw_without_replacement_shuffler #(
    parameter int MAX_VALUES = dwrs_pkg::MAX_VALUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dwrs_in_if.sink                          draw_in,
    dwrs_out_if.source                       draw_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dwrs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [dwrs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [dwrs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import dwrs_pkg::*;

    localparam int PW = $clog2(MAX_VALUES);
    localparam int SW = $clog2(MAX_VALUES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_ADVANCE,
        S_MUL,
        S_READ,
        S_WRA,
        S_WRB
    } state_t;

    cfg_t cfg;

    state_t             state_reg,      state_next;
    action_t            act_reg,        act_next;
    logic [31:0]        word_reg,       word_next;
    logic [PW-1:0]      position_reg,   position_next;
    logic [SW-1:0]      span_reg,       span_next;
    logic signed [31:0] built_min_reg,  built_min_next;
    logic signed [31:0] built_max_reg,  built_max_next;
    logic               rebuild_due_reg, rebuild_due_next;
    logic               dealt_none_reg, dealt_none_next;
    logic               dirty_reg,      dirty_next;
    logic               draw_pend_reg,  draw_pend_next;
    logic [PW-1:0]      fill_reg,       fill_next;
    logic [SW-1:0]      count_reg,      count_next;
    logic [PW-1:0]      r_reg,          r_next;
    logic [PW-1:0]      addr_a_reg,     addr_a_next;
    logic [PW-1:0]      addr_b_reg,     addr_b_next;
    logic               out_valid_reg,  out_valid_next;
    logic [31:0]        out_data_reg,   out_data_next;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW-1:0] ram_wdata;
    logic          ram_re;
    logic [PW-1:0] ram_raddr_a;
    logic [PW-1:0] ram_raddr_b;
    logic [PW-1:0] ram_rdata_a;
    logic [PW-1:0] ram_rdata_b;

    logic [32:0]      bound_diff;
    logic [SW-1:0]    span_calc;
    logic             rebuild_needed;
    logic [SW-1:0]    pos_inc;
    logic [PW-1:0]    pos_adv;
    logic [SW-1:0]    count_calc;
    logic [31+SW:0]   prod;

    dwrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dwrs_perm_ram #(
        .DEPTH (MAX_VALUES),
        .AW    (PW),
        .DW    (PW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_en     (ram_re),
        .rd_addr_a (ram_raddr_a),
        .rd_addr_b (ram_raddr_b),
        .rd_data_a (ram_rdata_a),
        .rd_data_b (ram_rdata_b)
    );

    // span of the configured range: reversed bounds give 1, wide ranges saturate
    always_comb
    begin
        bound_diff = {cfg.max_value[31], cfg.max_value} - {cfg.min_value[31], cfg.min_value};
        if (bound_diff[32])
        begin
            span_calc = SW'(1);
        end
        else if (bound_diff >= 33'(MAX_VALUES))
        begin
            span_calc = SW'(MAX_VALUES);
        end
        else
        begin
            span_calc = bound_diff[SW-1:0] + SW'(1);
        end
    end

    assign rebuild_needed = rebuild_due_reg || (cfg.min_value != built_min_reg)
                            || (cfg.max_value != built_max_reg);

    // position step with wrap, and how many entries are left to pick from
    always_comb
    begin
        pos_inc = SW'(position_reg) + SW'(1);
        pos_adv = (pos_inc >= span_reg) ? '0 : pos_inc[PW-1:0];
        count_calc = span_reg - SW'(pos_adv);
        if (cfg.no_repeat && (count_calc > SW'(1)))
        begin
            count_calc = count_calc - SW'(1);
        end
    end

    assign prod = (32+SW)'(word_reg) * (32+SW)'(count_reg);

    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        word_next        = word_reg;
        position_next    = position_reg;
        span_next        = span_reg;
        built_min_next   = built_min_reg;
        built_max_next   = built_max_reg;
        rebuild_due_next = rebuild_due_reg;
        dealt_none_next  = dealt_none_reg;
        dirty_next       = dirty_reg;
        draw_pend_next   = draw_pend_reg;
        fill_next        = fill_reg;
        count_next       = count_reg;
        r_next           = r_reg;
        addr_a_next      = addr_a_reg;
        addr_b_next      = addr_b_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        ram_we      = 1'b0;
        ram_waddr   = addr_a_reg;
        ram_wdata   = ram_rdata_b;
        ram_re      = 1'b0;
        ram_raddr_a = addr_a_reg;
        ram_raddr_b = addr_b_reg;

        if (out_valid_reg && draw_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (draw_in.valid)
                begin
                    act_next   = action_t'(draw_in.action);
                    word_next  = draw_in.random_word;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (act_reg) inside
                    ACT_RESHUFFLE, ACT_RESTART:
                    begin
                        if (dealt_none_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            addr_a_next = position_reg;
                            addr_b_next = PW'(span_reg - SW'(1));
                            if ((act_reg == ACT_RESTART) || (position_reg == '0))
                            begin
                                position_next = PW'(span_reg - SW'(1));
                            end
                            else
                            begin
                                position_next = position_reg - PW'(1);
                            end
                            state_next = S_READ;
                        end
                    end
                    ACT_DRAW, ACT_REBUILD:
                    begin
                        if ((act_reg == ACT_REBUILD) || rebuild_needed)
                        begin
                            span_next        = span_calc;
                            position_next    = PW'(span_calc - SW'(1));
                            built_min_next   = cfg.min_value;
                            built_max_next   = cfg.max_value;
                            rebuild_due_next = 1'b0;
                            draw_pend_next   = (act_reg == ACT_DRAW);
                            fill_next        = '0;
                            if (dirty_reg)
                            begin
                                state_next = S_WALK;
                            end
                            else
                            begin
                                state_next = (act_reg == ACT_DRAW) ? S_ADVANCE : S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_ADVANCE;
                        end
                        dealt_none_next = 1'b0;
                    end
                endcase
            end

            // rewrite the identity, one entry a cycle
            S_WALK:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                ram_wdata = fill_reg;
                if (fill_reg == PW'(MAX_VALUES - 1))
                begin
                    dirty_next = 1'b0;
                    state_next = draw_pend_reg ? S_ADVANCE : S_IDLE;
                end
                else
                begin
                    fill_next = fill_reg + PW'(1);
                end
            end

            S_ADVANCE:
            begin
                position_next = pos_adv;
                addr_a_next   = pos_adv;
                count_next    = count_calc;
                state_next    = S_MUL;
            end

            S_MUL:
            begin
                r_next     = prod[32+PW-1:32];
                state_next = S_READ;
            end

            S_READ:
            begin
                ram_re = 1'b1;
                if (act_reg == ACT_DRAW)
                begin
                    ram_raddr_b = addr_a_reg + r_reg;
                end
                addr_b_next = ram_raddr_b;
                state_next  = S_WRA;
            end

            S_WRA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_a_reg;
                ram_wdata  = ram_rdata_b;
                state_next = S_WRB;
            end

            // second half of the swap; a draw also waits here for the output register
            S_WRB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_b_reg;
                ram_wdata  = ram_rdata_a;
                dirty_next = 1'b1;
                if (act_reg == ACT_DRAW)
                begin
                    if (!out_valid_reg || draw_out.ready)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = built_min_reg + 32'(ram_rdata_b);
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_WALK;
            act_reg         <= ACT_DRAW;
            position_reg    <= PW'(1);
            span_reg        <= SW'(2);
            built_min_reg   <= 32'sd0;
            built_max_reg   <= 32'sd1;
            rebuild_due_reg <= 1'b1;
            dealt_none_reg  <= 1'b1;
            dirty_reg       <= 1'b1;
            draw_pend_reg   <= 1'b0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            act_reg         <= act_next;
            position_reg    <= position_next;
            span_reg        <= span_next;
            built_min_reg   <= built_min_next;
            built_max_reg   <= built_max_next;
            rebuild_due_reg <= rebuild_due_next;
            dealt_none_reg  <= dealt_none_next;
            dirty_reg       <= dirty_next;
            draw_pend_reg   <= draw_pend_next;
            fill_reg        <= fill_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        count_reg    <= count_next;
        r_reg        <= r_next;
        addr_a_reg   <= addr_a_next;
        addr_b_reg   <= addr_b_next;
    end

    assign draw_in.ready        = (state_reg == S_IDLE);
    assign draw_out.valid       = out_valid_reg;
    assign draw_out.drawn_value = out_data_reg;

endmodule

/* hw/rtl/dwrs_checker.sv */
// port-level assertions for the shuffler, bound to the top level
// depends on dwrs_pkg for the configuration port widths

module dwrs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [31:0]                      drawn_value,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [dwrs_pkg::CFG_ADDR_W-1:0]  paddr,
    input logic [dwrs_pkg::CFG_DATA_W-1:0]  pwdata,
    input logic [dwrs_pkg::CFG_DATA_W-1:0]  prdata
);
    import dwrs_pkg::*;

    // a pending result is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(drawn_value))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous item still in work");

    // a result only appears at the end of an item's work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while sequencer was idle");

    // min_value reads back what was just written
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr == CFG_ADDR_W'(0))
        |=> !(psel && !pwrite && (paddr == CFG_ADDR_W'(0))) || (prdata == $past(pwdata)))
        else $error("min_value readback mismatch");

endmodule

bind draw_without_replacement_shuffler dwrs_checker u_dwrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (draw_in.valid),
    .in_ready    (draw_in.ready),
    .out_valid   (draw_out.valid),
    .out_ready   (draw_out.ready),
    .drawn_value (draw_out.drawn_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
